// File: sv/wtpq_pkg.sv
// Package: shared constants, types and controller/datapath links for the task queue.
`timescale 1ns / 1ps

package wtpq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int FIELD_W     = 8;
    localparam int SCORE_W     = 12;
    localparam int COUNT_W     = 7;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic {
        MODE_COUNT      = 1'b0,
        MODE_RESILIENCE = 1'b1
    } t_mode;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture the item and its score
        logic exec;   // update the slot row and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // result register empty or draining this cycle
    } t_status;

endpackage

// File: sv/wtpq_ifs.sv
// Interfaces: request and response channels of the task queue.
`timescale 1ns / 1ps

interface wtpq_req_if import wtpq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [ID_W-1:0]    task_id;
    logic [FIELD_W-1:0] task_priority;
    logic [FIELD_W-1:0] task_weight;
    logic               task_critical;

    modport source (
        output valid, operation, task_id, task_priority, task_weight, task_critical,
        input  ready
    );
    modport sink (
        input  valid, operation, task_id, task_priority, task_weight, task_critical,
        output ready
    );
endinterface

interface wtpq_rsp_if import wtpq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               done_ok;
    logic [ID_W-1:0]    out_task_id;
    logic [SCORE_W-1:0] out_score;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, done_ok, out_task_id, out_score, entry_count,
        input  ready
    );
    modport sink (
        input  valid, done_ok, out_task_id, out_score, entry_count,
        output ready
    );
endinterface

// File: sv/wtpq_ctrl.sv
// Controller: two-state sequencer that takes one item and runs it through the slot row.
`timescale 1ns / 1ps

module wtpq_ctrl import wtpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here while the previous result is still unclaimed
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/wtpq_dp.sv
// Datapath: score unit, compare-and-shift slot row, fill count and result register.
`timescale 1ns / 1ps

module wtpq_dp import wtpq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    // item payload
    input  logic               i_operation,
    input  logic [ID_W-1:0]    i_task_id,
    input  logic [FIELD_W-1:0] i_task_priority,
    input  logic [FIELD_W-1:0] i_task_weight,
    input  logic               i_task_critical,
    // result
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_done_ok,
    output logic [ID_W-1:0]    o_out_task_id,
    output logic [SCORE_W-1:0] o_out_score,
    output logic [COUNT_W-1:0] o_entry_count
);

    t_mode              r_mode;
    t_op                r_op;
    logic [ID_W-1:0]    r_id;
    logic [SCORE_W-1:0] r_score, n_score;

    logic [ID_W-1:0]    r_slot_id    [QUEUE_DEPTH];
    logic [SCORE_W-1:0] r_slot_score [QUEUE_DEPTH];
    logic [ID_W-1:0]    n_slot_id    [QUEUE_DEPTH];
    logic [SCORE_W-1:0] n_slot_score [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_fill, n_fill;

    logic               r_out_valid;
    logic               r_done_ok;
    logic [ID_W-1:0]    r_out_id;
    logic [SCORE_W-1:0] r_out_score;
    logic [COUNT_W-1:0] r_out_count;

    logic [QUEUE_DEPTH-1:0] w_ge;
    logic                   w_full, w_empty, w_do_ins, w_do_pop;
    logic [SCORE_W-1:0]     w_p, w_w;

    // score x10: mode 0 is 5p+5w, mode 1 is 3p+2w+5c
    always_comb begin
        w_p = SCORE_W'(i_task_priority);
        w_w = SCORE_W'(i_task_weight);
        if (r_mode == MODE_COUNT) begin
            n_score = (w_p << 2) + w_p + (w_w << 2) + w_w;
        end else begin
            n_score = (w_p << 1) + w_p + (w_w << 1)
                    + (i_task_critical ? SCORE_W'(5) : SCORE_W'(0));
        end
    end

    assign w_full   = (r_fill == CNT_W'(QUEUE_DEPTH));
    assign w_empty  = (r_fill == '0);
    assign w_do_ins = i_cmd.exec && (r_op == OP_ENQ) && !w_full;
    assign w_do_pop = i_cmd.exec && (r_op == OP_DEQ) && !w_empty;

    // ge marks occupied slots that stay ahead of the new entry (ties keep order)
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ge[i] = (CNT_W'(i) < r_fill) && (r_slot_score[i] >= r_score);
        end
    end

    // one cell per slot, each looks only at its neighbors
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic w_here;
        if (g == 0) begin : g_head
            assign w_here = 1'b1;
        end else begin : g_body
            assign w_here = w_ge[g-1];
        end

        always_comb begin
            n_slot_id[g]    = r_slot_id[g];
            n_slot_score[g] = r_slot_score[g];
            if (w_do_ins && !w_ge[g]) begin
                if (w_here) begin
                    n_slot_id[g]    = r_id;
                    n_slot_score[g] = r_score;
                end else begin
                    n_slot_id[g]    = r_slot_id[(g == 0) ? 0 : g - 1];
                    n_slot_score[g] = r_slot_score[(g == 0) ? 0 : g - 1];
                end
            end else if (w_do_pop && (g < QUEUE_DEPTH - 1)) begin
                n_slot_id[g]    = r_slot_id[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                n_slot_score[g] = r_slot_score[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (w_do_ins) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (w_do_pop) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESILIENCE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_mode'(i_cfg_wdata);
            end
            r_fill <= n_fill;
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_operation);
            r_id    <= i_task_id;
            r_score <= n_score;
        end
        r_slot_id    <= n_slot_id;
        r_slot_score <= n_slot_score;
        if (i_cmd.exec) begin
            r_done_ok   <= w_do_ins || w_do_pop;
            r_out_count <= COUNT_W'(n_fill);
            if (w_do_ins) begin
                r_out_id    <= r_id;
                r_out_score <= r_score;
            end else if (w_do_pop) begin
                r_out_id    <= r_slot_id[0];
                r_out_score <= r_slot_score[0];
            end else begin
                r_out_id    <= '0;
                r_out_score <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_done_ok     = r_done_ok;
    assign o_out_task_id = r_out_id;
    assign o_out_score   = r_out_score;
    assign o_entry_count = r_out_count;

endmodule

// File: sv/weighted_task_priority_queue_core.sv
// Top level: weighted task priority queue, controller plus datapath.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// i_req     in   valid/ready        operation, task_id, task_priority, task_weight,
//                                   task_critical
// o_rsp     out  valid/ready        done_ok, out_task_id, out_score, entry_count
// i_cfg_*   in   write enable only  goal_mode (1 bit, reset 1)
//
// For each item, IDLE registers the item with its score on accept, and EXEC then runs the
// compare-and-shift slot row and loads the result register.
// A new item is taken in the cycle after that, while the last result may still wait.
// If the result register is still occupied, the row update waits until it drains.
// Reset (i_rst_n low, synchronous) empties the queue and sets goal_mode to 1.
// Slot contents need no clearing: only slots below the fill count are read.

module weighted_task_priority_queue_core import wtpq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    wtpq_req_if.sink   i_req,
    wtpq_rsp_if.source o_rsp
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: IDLE takes an item, EXEC applies it once the result slot is free.
    wtpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_status   (w_status),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd)
    );

    // Score unit, sorted slot row (slot 0 holds the highest score), result register.
    wtpq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_req.operation),
        .i_task_id       (i_req.task_id),
        .i_task_priority (i_req.task_priority),
        .i_task_weight   (i_req.task_weight),
        .i_task_critical (i_req.task_critical),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_done_ok       (o_rsp.done_ok),
        .o_out_task_id   (o_rsp.out_task_id),
        .o_out_score     (o_rsp.out_score),
        .o_entry_count   (o_rsp.entry_count)
    );

`ifndef SYNTH
    // One item in flight: no second accept right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while previous item still in work");

    // The row update only fires when the result register can take its item.
    a_exec_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> w_status.out_free)
        else $error("row update with result register blocked");

    // A failed operation reports no handle and no score.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.done_ok) |->
            (o_rsp.out_task_id == '0 && o_rsp.out_score == '0))
        else $error("failed operation returned a payload");

    // The reported count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.entry_count <= COUNT_W'(QUEUE_DEPTH)))
        else $error("entry count above queue depth");
`endif

endmodule
